@@ src/bpc_pkg.sv @@
package bpc_pkg;

    localparam int unsigned TimeW  = 32;
    localparam int unsigned CfgW   = 16;
    localparam int unsigned CntW   = 32;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned NumStat = 5;

    // tdata layouts, lowest bit first, padded to whole bytes
    localparam int unsigned InW  = 40;
    localparam int unsigned OutW = 168;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_SINGLE   = 3'd1,
        EV_DOUBLE   = 3'd2,
        EV_LONG     = 3'd3,
        EV_EXTRA    = 3'd4,
        EV_RELEASED = 3'd5
    } event_t;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_DEBOUNCE   = 3'd0,
        CFG_LONG_HOLD  = 3'd1,
        CFG_EXTRA_HOLD = 3'd2,
        CFG_DOUBLE_WIN = 3'd3,
        CFG_BOOT_DELAY = 3'd4
    } cfg_idx_t;

    // statistics counter slots
    localparam int unsigned ST_TOTAL   = 0;
    localparam int unsigned ST_SINGLE  = 1;
    localparam int unsigned ST_DOUBLE  = 2;
    localparam int unsigned ST_LONG    = 3;
    localparam int unsigned ST_IGNORED = 4;

    localparam logic [CfgW-1:0] DEBOUNCE_RST   = 16'd50;
    localparam logic [CfgW-1:0] LONG_HOLD_RST  = 16'd2000;
    localparam logic [CfgW-1:0] EXTRA_HOLD_RST = 16'd4000;
    localparam logic [CfgW-1:0] DOUBLE_WIN_RST = 16'd400;
    localparam logic [CfgW-1:0] BOOT_DELAY_RST = 16'd5000;

endpackage

@@ src/button_press_classifier_top.sv @@
// debounced push-button classifier for one active-low button. every input transfer is
// one poll (raw pin level, 32-bit millisecond stamp) and produces exactly one result
// transfer carrying the event code, the debounced held flag and five wrapping statistics
// counters. the first poll after reset only latches boot time and level; pressed polls
// during the boot delay are counted as ignored; a press still held when the delay ends is
// absorbed without an event. timing: one poll per clock while s_tready is high; results
// appear in the cycle after the poll is taken. the whole step is a handful of 32-bit
// wrapping subtractions and compares between the input handshake and the result register,
// and s_tready stays high out of reset as long as the result register is empty or being
// drained. configuration registers are written through the cfg_ channel, which is ready
// whenever reset is released; write them only while idle.
module button_press_classifier_top (
    input  logic                          aclk,
    input  logic                          aresetn,

    // poll input
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bpc_pkg::InW-1:0]       s_tdata,   // raw_level[0], now_ms[32:1], zero pad

    // result output
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bpc_pkg::OutW-1:0]      m_tdata,   // event_res[2:0], held[3],
                                                     // total_count[35:4], single_count[67:36],
                                                     // double_count[99:68], long_count[131:100],
                                                     // ignored_count[163:132], zero pad

    // configuration write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bpc_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [bpc_pkg::CfgW-1:0]      cfg_wdata
);

    localparam int unsigned TW = bpc_pkg::TimeW;
    localparam int unsigned CW = bpc_pkg::CntW;

    // configuration registers
    logic [bpc_pkg::CfgW-1:0] debounce_reg, long_hold_reg, extra_hold_reg;
    logic [bpc_pkg::CfgW-1:0] double_win_reg, boot_delay_reg;

    // classifier state
    logic          started_reg,   started_next;
    logic          boot_wait_reg, boot_wait_next;
    logic [TW-1:0] boot_stamp_reg, boot_stamp_next;
    logic          cand_reg,      cand_next;      // candidate level, 1 = released
    logic          prev_reg,      prev_next;      // debounced stable level
    logic [TW-1:0] change_reg,    change_next;
    logic [TW-1:0] press_reg,     press_next;
    logic [TW-1:0] release_reg,   release_next;
    logic [1:0]    tally_reg,     tally_next;
    logic          long_reg,      long_next;
    logic          extra_reg,     extra_next;
    logic [CW-1:0] stat_reg  [bpc_pkg::NumStat];
    logic [CW-1:0] stat_next [bpc_pkg::NumStat];

    // result register
    logic                     m_tvalid_reg;
    logic [bpc_pkg::OutW-1:0] m_tdata_reg, m_tdata_next;

    logic          s_accept;
    logic          lvl;
    logic [TW-1:0] now_ms;
    bpc_pkg::event_t ev;

    assign lvl      = s_tdata[0];
    assign now_ms   = s_tdata[TW:1];
    assign s_tready = aresetn && (!m_tvalid_reg || m_tready);
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign cfg_ready = aresetn;

    // config writes, unknown indexes dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg   <= bpc_pkg::DEBOUNCE_RST;
            long_hold_reg  <= bpc_pkg::LONG_HOLD_RST;
            extra_hold_reg <= bpc_pkg::EXTRA_HOLD_RST;
            double_win_reg <= bpc_pkg::DOUBLE_WIN_RST;
            boot_delay_reg <= bpc_pkg::BOOT_DELAY_RST;
        end else if (cfg_valid) begin
            case (bpc_pkg::cfg_idx_t'(cfg_index))
                bpc_pkg::CFG_DEBOUNCE:   debounce_reg   <= cfg_wdata;
                bpc_pkg::CFG_LONG_HOLD:  long_hold_reg  <= cfg_wdata;
                bpc_pkg::CFG_EXTRA_HOLD: extra_hold_reg <= cfg_wdata;
                bpc_pkg::CFG_DOUBLE_WIN: double_win_reg <= cfg_wdata;
                bpc_pkg::CFG_BOOT_DELAY: boot_delay_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // one poll step; every time difference is a wrapping 32-bit subtract
    always_comb begin
        logic          classify;
        logic          pressed, was;
        logic [TW-1:0] hold;
        logic [1:0]    tally_v;
        logic [bpc_pkg::NumStat-1:0] bump;

        started_next   = started_reg;
        boot_wait_next = boot_wait_reg;
        boot_stamp_next = boot_stamp_reg;
        cand_next      = cand_reg;
        prev_next      = prev_reg;
        change_next    = change_reg;
        press_next     = press_reg;
        release_next   = release_reg;
        tally_next     = tally_reg;
        long_next      = long_reg;
        extra_next     = extra_reg;
        ev             = bpc_pkg::EV_NONE;
        bump           = '0;
        classify       = 1'b0;
        pressed        = (cand_reg == 1'b0);
        was            = (prev_reg == 1'b0);
        hold           = now_ms - press_reg;
        tally_v        = tally_reg;

        if (!started_reg) begin
            // initialization poll
            started_next    = 1'b1;
            boot_wait_next  = 1'b1;
            boot_stamp_next = now_ms;
            cand_next       = lvl;
            prev_next       = lvl;
            change_next     = now_ms;
        end else begin
            classify = 1'b1;
            if (boot_wait_reg) begin
                if ((now_ms - boot_stamp_reg) >= TW'(boot_delay_reg)) begin
                    boot_wait_next = 1'b0;
                    if (!lvl) begin
                        // held through the boot delay: absorb it
                        cand_next   = 1'b0;
                        prev_next   = 1'b0;
                        change_next = now_ms;
                        classify    = 1'b0;
                    end
                end else begin
                    bump[bpc_pkg::ST_IGNORED] = !lvl;
                    classify = 1'b0;
                end
            end
        end

        if (classify) begin
            if (lvl != cand_reg) begin
                cand_next   = lvl;
                change_next = now_ms;
            end else if ((now_ms - change_reg) >= TW'(debounce_reg)) begin
                if (pressed && !was) begin
                    press_next = now_ms;
                    long_next  = 1'b0;
                    extra_next = 1'b0;
                    tally_v    = tally_reg + 2'd1;
                    bump[bpc_pkg::ST_TOTAL] = 1'b1;
                    if (tally_v == 2'd2) begin
                        if ((now_ms - release_reg) <= TW'(double_win_reg)) begin
                            ev      = bpc_pkg::EV_DOUBLE;
                            bump[bpc_pkg::ST_DOUBLE] = 1'b1;
                            tally_v = 2'd0;
                        end else begin
                            tally_v = 2'd1;
                        end
                    end
                end

                if (pressed && was) begin
                    if (!extra_reg && hold >= TW'(extra_hold_reg)) begin
                        extra_next = 1'b1;
                        long_next  = 1'b1;
                        tally_v    = 2'd0;
                        ev         = bpc_pkg::EV_EXTRA;
                        bump[bpc_pkg::ST_LONG] = 1'b1;
                    end else if (!long_reg && hold >= TW'(long_hold_reg)) begin
                        long_next = 1'b1;
                        tally_v   = 2'd0;
                        ev        = bpc_pkg::EV_LONG;
                        bump[bpc_pkg::ST_LONG] = 1'b1;
                    end
                end

                if (!pressed && was) begin
                    release_next = now_ms;
                    ev           = bpc_pkg::EV_RELEASED;
                end

                // single press confirmed once the double window has run out
                if (!pressed && tally_v != 2'd0) begin
                    if ((now_ms - release_next) > TW'(double_win_reg)) begin
                        if (tally_v == 2'd1 && !long_next) begin
                            ev = bpc_pkg::EV_SINGLE;
                            bump[bpc_pkg::ST_SINGLE] = 1'b1;
                        end
                        tally_v = 2'd0;
                    end
                end

                tally_next = tally_v;
                prev_next  = cand_reg;
            end
        end

        for (int i = 0; i < bpc_pkg::NumStat; i++) begin
            stat_next[i] = bump[i] ? stat_reg[i] + CW'(1) : stat_reg[i];
        end
    end

    // result word in tdata order
    always_comb begin
        m_tdata_next = '0;
        m_tdata_next[2:0] = ev;
        m_tdata_next[3]   = !prev_next;
        for (int i = 0; i < bpc_pkg::NumStat; i++) begin
            m_tdata_next[4 + i*CW +: CW] = stat_next[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg    <= 1'b0;
            boot_wait_reg  <= 1'b1;
            boot_stamp_reg <= '0;
            cand_reg       <= 1'b1;
            prev_reg       <= 1'b1;
            change_reg     <= '0;
            press_reg      <= '0;
            release_reg    <= '0;
            tally_reg      <= '0;
            long_reg       <= 1'b0;
            extra_reg      <= 1'b0;
            for (int i = 0; i < bpc_pkg::NumStat; i++) begin
                stat_reg[i] <= '0;
            end
        end else if (s_accept) begin
            started_reg    <= started_next;
            boot_wait_reg  <= boot_wait_next;
            boot_stamp_reg <= boot_stamp_next;
            cand_reg       <= cand_next;
            prev_reg       <= prev_next;
            change_reg     <= change_next;
            press_reg      <= press_next;
            release_reg    <= release_next;
            tally_reg      <= tally_next;
            long_reg       <= long_next;
            extra_reg      <= extra_next;
            for (int i = 0; i < bpc_pkg::NumStat; i++) begin
                stat_reg[i] <= stat_next[i];
            end
        end
    end

    // result register: loads on every poll transfer, empties when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    // the initialization poll never reports an event
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && !started_reg |=> m_tdata_reg[2:0] == bpc_pkg::EV_NONE)
        else $error("event reported on initialization poll");

    // polls inside the boot delay never report an event
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && started_reg && boot_wait_reg
            && ((now_ms - boot_stamp_reg) < TW'(boot_delay_reg))
        |=> m_tdata_reg[2:0] == bpc_pkg::EV_NONE)
        else $error("event reported during boot delay");

    // pending press tally is always resolved within the poll
    assert property (@(posedge aclk) disable iff (!aresetn)
        tally_reg == 2'd0 || tally_reg == 2'd1)
        else $error("press tally left above one");

    // total press count steps by at most one per poll
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> stat_reg[bpc_pkg::ST_TOTAL] == $past(stat_reg[bpc_pkg::ST_TOTAL])
            || stat_reg[bpc_pkg::ST_TOTAL] == $past(stat_reg[bpc_pkg::ST_TOTAL]) + CW'(1))
        else $error("total count jumped");

endmodule
